// ===== rtl/tgr_pkg.sv =====
// shared types, constants and font tables for the text glyph rasterizer
// no dependencies; imported by every module of the block
package tgr_pkg;

	// glyph geometry
	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_ROWS = 7;
	localparam int GLYPH_DOTS = GLYPH_COLS * GLYPH_ROWS;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// special character and glyph codes
	localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
	localparam logic [5:0] GLYPH_SPACE    = 6'd0;
	localparam logic [5:0] GLYPH_DIGIT0   = 6'd27;
	localparam logic [5:0] GLYPH_QUESTION = 6'd44;

	typedef logic [GLYPH_DOTS-1:0] dots_t;

	// one drawing job handed from front to back
	typedef struct packed {
		dots_t       dots;
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  scale;
		logic [15:0] color;
	} tgr_entry_t;

	// pack five 7-bit columns, column c at bits [7c+6:7c], bit r is row r
	function automatic dots_t pack_cols(input logic [6:0] c0, input logic [6:0] c1,
		input logic [6:0] c2, input logic [6:0] c3, input logic [6:0] c4);
		return {c4, c3, c2, c1, c0};
	endfunction

	// character code to glyph number
	function automatic logic [5:0] glyph_index(input logic [7:0] code_in);
		logic [7:0] code;
		logic [5:0] idx;
		code = code_in;
		if (code inside {[8'h61:8'h7A]})
			code = code - 8'h20;
		idx = GLYPH_QUESTION;
		if (code == 8'h20)
			idx = GLYPH_SPACE;
		else if (code inside {[8'h41:8'h5A]})
			idx = 6'(code - 8'h40);
		else if (code inside {[8'h30:8'h39]})
			idx = GLYPH_DIGIT0 + 6'(code - 8'h30);
		else begin
			case (code)
				8'h2E: idx = 6'd37;
				8'h3A: idx = 6'd38;
				8'h2F: idx = 6'd39;
				8'h25: idx = 6'd40;
				8'h2B: idx = 6'd41;
				8'h5F: idx = 6'd42;
				8'h21: idx = 6'd43;
				8'h2D: idx = 6'd45;
				8'h3D: idx = 6'd46;
				default: idx = GLYPH_QUESTION;
			endcase
		end
		return idx;
	endfunction

	// font rom: glyph number to dot mask
	function automatic dots_t glyph_dots(input logic [5:0] idx);
		dots_t d;
		case (idx)
			6'd0:  d = pack_cols(7'h00, 7'h00, 7'h00, 7'h00, 7'h00);
			6'd1:  d = pack_cols(7'h7E, 7'h09, 7'h09, 7'h7E, 7'h00);
			6'd2:  d = pack_cols(7'h7F, 7'h49, 7'h49, 7'h36, 7'h00);
			6'd3:  d = pack_cols(7'h3E, 7'h41, 7'h41, 7'h22, 7'h00);
			6'd4:  d = pack_cols(7'h7F, 7'h41, 7'h41, 7'h3E, 7'h00);
			6'd5:  d = pack_cols(7'h7F, 7'h49, 7'h49, 7'h41, 7'h00);
			6'd6:  d = pack_cols(7'h7F, 7'h09, 7'h09, 7'h01, 7'h00);
			6'd7:  d = pack_cols(7'h3E, 7'h41, 7'h51, 7'h32, 7'h00);
			6'd8:  d = pack_cols(7'h7F, 7'h08, 7'h08, 7'h7F, 7'h00);
			6'd9:  d = pack_cols(7'h41, 7'h7F, 7'h41, 7'h00, 7'h00);
			6'd10: d = pack_cols(7'h20, 7'h40, 7'h41, 7'h3F, 7'h00);
			6'd11: d = pack_cols(7'h7F, 7'h08, 7'h14, 7'h63, 7'h00);
			6'd12: d = pack_cols(7'h7F, 7'h40, 7'h40, 7'h40, 7'h00);
			6'd13: d = pack_cols(7'h7F, 7'h06, 7'h06, 7'h7F, 7'h00);
			6'd14: d = pack_cols(7'h7F, 7'h06, 7'h18, 7'h7F, 7'h00);
			6'd15: d = pack_cols(7'h3E, 7'h41, 7'h41, 7'h3E, 7'h00);
			6'd16: d = pack_cols(7'h7F, 7'h09, 7'h09, 7'h06, 7'h00);
			6'd17: d = pack_cols(7'h3E, 7'h41, 7'h61, 7'h7E, 7'h00);
			6'd18: d = pack_cols(7'h7F, 7'h09, 7'h19, 7'h66, 7'h00);
			6'd19: d = pack_cols(7'h26, 7'h49, 7'h49, 7'h32, 7'h00);
			6'd20: d = pack_cols(7'h01, 7'h7F, 7'h01, 7'h01, 7'h00);
			6'd21: d = pack_cols(7'h3F, 7'h40, 7'h40, 7'h3F, 7'h00);
			6'd22: d = pack_cols(7'h1F, 7'h20, 7'h40, 7'h3F, 7'h00);
			6'd23: d = pack_cols(7'h7F, 7'h30, 7'h30, 7'h7F, 7'h00);
			6'd24: d = pack_cols(7'h63, 7'h14, 7'h14, 7'h63, 7'h00);
			6'd25: d = pack_cols(7'h07, 7'h08, 7'h70, 7'h07, 7'h00);
			6'd26: d = pack_cols(7'h61, 7'h51, 7'h49, 7'h47, 7'h00);
			6'd27: d = pack_cols(7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E);
			6'd28: d = pack_cols(7'h00, 7'h42, 7'h7F, 7'h40, 7'h00);
			6'd29: d = pack_cols(7'h42, 7'h61, 7'h51, 7'h49, 7'h46);
			6'd30: d = pack_cols(7'h21, 7'h41, 7'h45, 7'h4B, 7'h31);
			6'd31: d = pack_cols(7'h18, 7'h14, 7'h12, 7'h7F, 7'h10);
			6'd32: d = pack_cols(7'h27, 7'h45, 7'h45, 7'h45, 7'h39);
			6'd33: d = pack_cols(7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30);
			6'd34: d = pack_cols(7'h01, 7'h71, 7'h09, 7'h05, 7'h03);
			6'd35: d = pack_cols(7'h36, 7'h49, 7'h49, 7'h49, 7'h36);
			6'd36: d = pack_cols(7'h06, 7'h49, 7'h49, 7'h29, 7'h1E);
			6'd37: d = pack_cols(7'h00, 7'h60, 7'h60, 7'h00, 7'h00);
			6'd38: d = pack_cols(7'h00, 7'h36, 7'h36, 7'h00, 7'h00);
			6'd39: d = pack_cols(7'h60, 7'h18, 7'h06, 7'h01, 7'h00);
			6'd40: d = pack_cols(7'h63, 7'h13, 7'h08, 7'h64, 7'h63);
			6'd41: d = pack_cols(7'h08, 7'h08, 7'h3E, 7'h08, 7'h08);
			6'd42: d = pack_cols(7'h40, 7'h40, 7'h40, 7'h40, 7'h40);
			6'd43: d = pack_cols(7'h00, 7'h00, 7'h5F, 7'h00, 7'h00);
			6'd44: d = pack_cols(7'h02, 7'h01, 7'h51, 7'h09, 7'h06);
			6'd45: d = pack_cols(7'h08, 7'h08, 7'h08, 7'h08, 7'h00);
			6'd46: d = pack_cols(7'h14, 7'h14, 7'h14, 7'h14, 7'h14);
			default: d = '0;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/tgr_front.sv =====
// front end: accepts characters, keeps the cursor, looks up glyphs
// depends on tgr_pkg; pushes drawing jobs into tgr_fifo
module tgr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          char_code,
	input  logic                first_of_string,
	input  logic signed [15:0]  origin_x,
	input  logic signed [15:0]  origin_y,
	input  logic [15:0]         ink_color,
	input  logic [7:0]          pixel_scale,
	input  logic                q_full,
	output logic                push,
	output tgr_pkg::tgr_entry_t push_entry
);
	import tgr_pkg::*;

	logic [15:0] cursor_x_q;
	logic [15:0] cursor_y_q;
	logic [15:0] line_start_q;

	logic        accept;
	logic        is_newline;
	logic        zero_scale;
	logic [5:0]  glyph;
	dots_t       dots;
	logic [15:0] base_x;
	logic [15:0] base_y;
	logic [15:0] line_x;
	logic [15:0] advance;
	logic [15:0] pitch;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	// classify the word
	always_comb begin
		is_newline = (char_code == CHAR_NEWLINE);
		zero_scale = (pixel_scale == 8'd0);
		glyph      = glyph_index(char_code);
		dots       = glyph_dots(glyph);
		base_x     = first_of_string ? origin_x : cursor_x_q;
		base_y     = first_of_string ? origin_y : cursor_y_q;
		line_x     = first_of_string ? origin_x : line_start_q;
		advance    = 16'({pixel_scale, 2'b00}) + 16'({pixel_scale, 1'b0});
		pitch      = 16'({pixel_scale, 3'b000});
	end

	// job for the back end, only for glyphs with dots and a nonzero scale
	always_comb begin
		push             = accept && !zero_scale && !is_newline && (glyph != GLYPH_SPACE);
		push_entry.dots  = dots;
		push_entry.x     = base_x;
		push_entry.y     = base_y;
		push_entry.scale = pixel_scale;
		push_entry.color = ink_color;
	end

	// cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q   <= '0;
			cursor_y_q   <= '0;
			line_start_q <= '0;
		end else if (accept) begin
			line_start_q <= line_x;
			if (zero_scale) begin
				cursor_x_q <= base_x;
				cursor_y_q <= base_y;
			end else if (is_newline) begin
				cursor_x_q <= line_x;
				cursor_y_q <= base_y + pitch;
			end else begin
				cursor_x_q <= base_x + advance;
				cursor_y_q <= base_y;
			end
		end
	end

endmodule

// ===== rtl/tgr_fifo.sv =====
// short job queue between front and back, first word falls through
// depends on tgr_pkg for the job type
module tgr_fifo #(
	parameter int DEPTH = tgr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tgr_pkg::tgr_entry_t push_entry,
	input  logic                pop,
	output tgr_pkg::tgr_entry_t pop_entry,
	output logic                full,
	output logic                not_empty
);
	import tgr_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tgr_entry_t    slots_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_entry = slots_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= push_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/tgr_back.sv =====
// back end: walks the dots of one glyph, one square per cycle while out_stall is low
// depends on tgr_pkg; takes jobs from tgr_fifo, drives the output register
module tgr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  tgr_pkg::tgr_entry_t q_entry,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  rect_x,
	output logic signed [15:0]  rect_y,
	output logic [7:0]          rect_side,
	output logic [15:0]         rect_color,
	output logic                last_of_char
);
	import tgr_pkg::*;

	// current job
	logic        active_q;
	dots_t       dots_q;
	logic [15:0] x_q;
	logic [15:0] y_q;
	logic [7:0]  scale_q;
	logic [15:0] color_q;

	// output register
	logic        out_valid_q;
	logic [15:0] rect_x_q;
	logic [15:0] rect_y_q;
	logic [7:0]  rect_side_q;
	logic [15:0] rect_color_q;
	logic        last_q;

	logic        adv;
	logic        emit;
	logic        last_dot;
	dots_t       dots_next;
	logic [2:0]  col;
	logic [2:0]  row;
	logic [10:0] col_off;
	logic [10:0] row_off;

	// lowest set dot, columns outer and rows inner
	always_comb begin
		col = '0;
		row = '0;
		for (int c = GLYPH_COLS - 1; c >= 0; c--) begin
			for (int r = GLYPH_ROWS - 1; r >= 0; r--) begin
				if (dots_q[c*GLYPH_ROWS + r]) begin
					col = 3'(c);
					row = 3'(r);
				end
			end
		end
		dots_next = dots_q & (dots_q - 1'b1);
		last_dot  = (dots_next == '0);
		col_off   = 11'(col) * 11'(scale_q);
		row_off   = 11'(row) * 11'(scale_q);
	end

	assign adv   = !out_valid_q || !out_stall;
	assign emit  = adv && active_q;
	assign q_pop = q_not_empty && (!active_q || (emit && last_dot));

	// job registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (q_pop) begin
			active_q <= 1'b1;
		end else if (emit && last_dot) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			dots_q  <= q_entry.dots;
			x_q     <= q_entry.x;
			y_q     <= q_entry.y;
			scale_q <= q_entry.scale;
			color_q <= q_entry.color;
		end else if (emit) begin
			dots_q <= dots_next;
		end
	end

	// output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rect_x_q     <= x_q + 16'(col_off);
			rect_y_q     <= y_q + 16'(row_off);
			rect_side_q  <= scale_q;
			rect_color_q <= color_q;
			last_q       <= last_dot;
		end
	end

	assign out_valid    = out_valid_q;
	assign rect_x       = rect_x_q;
	assign rect_y       = rect_y_q;
	assign rect_side    = rect_side_q;
	assign rect_color   = rect_color_q;
	assign last_of_char = last_q;

endmodule

// ===== rtl/text_glyph_rasterizer_core.sv =====
// path: an accepted character passes a job queue slot, the back end job registers
// and the output register; space, newline and zero scale give no square
// throughput: one square per cycle while out_stall is low; each character gives
// one square per set dot of its glyph (4 to 19) in the dot walker of the back end
// reset: cursor, line start and the job queue clear at once, asynchronously
module text_glyph_rasterizer_core #(
	parameter int QUEUE_DEPTH = tgr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         char_code,
	input  logic               first_of_string,
	input  logic signed [15:0] origin_x,
	input  logic signed [15:0] origin_y,
	input  logic [15:0]        ink_color,
	input  logic [7:0]         pixel_scale,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] rect_x,
	output logic signed [15:0] rect_y,
	output logic [7:0]         rect_side,
	output logic [15:0]        rect_color,
	output logic               last_of_char
);
	import tgr_pkg::*;

	logic       q_full;
	logic       q_not_empty;
	logic       push;
	logic       pop;
	tgr_entry_t push_entry;
	tgr_entry_t pop_entry;

	// character front end
	tgr_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.char_code       (char_code),
		.first_of_string (first_of_string),
		.origin_x        (origin_x),
		.origin_y        (origin_y),
		.ink_color       (ink_color),
		.pixel_scale     (pixel_scale),
		.q_full          (q_full),
		.push            (push),
		.push_entry      (push_entry)
	);

	// job queue
	tgr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.full       (q_full),
		.not_empty  (q_not_empty)
	);

	// dot walker
	tgr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_entry      (pop_entry),
		.q_pop        (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.rect_x       (rect_x),
		.rect_y       (rect_y),
		.rect_side    (rect_side),
		.rect_color   (rect_color),
		.last_of_char (last_of_char)
	);

endmodule
